[sv/ohc_pkg.sv]
package ohc_pkg;

   // Header bytes kept per file and the index width into that store
   localparam int OHC_STORE_DEPTH = 20;
   localparam int OHC_IDX_W       = $clog2(OHC_STORE_DEPTH);
   localparam int OHC_CNT_W       = 7;
   localparam logic [OHC_CNT_W-1:0] OHC_COUNT_MAX = 7'd127;
   localparam int OHC_READ_WINDOW = 64;
   localparam int OHC_SIZE_W      = 48;

   // Header queue between front and back
   localparam int OHC_QDEPTH = 2;
   localparam int OHC_QPTR_W = 1;
   localparam int OHC_QCNT_W = 2;

   // Register file
   localparam int OHC_ADDR_W = 5;
   localparam logic [1:0] OHC_REG_MAX_SIZE = 2'd0;
   localparam logic [1:0] OHC_REG_MAX_SECS = 2'd1;
   localparam logic [1:0] OHC_REG_MAX_OPT  = 2'd2;
   localparam logic [47:0] OHC_RST_MAX_SIZE = 48'd536870912;
   localparam logic [15:0] OHC_RST_MAX_SECS = 16'd32768;
   localparam logic [15:0] OHC_RST_MAX_OPT  = 16'd4096;

   // Magic numbers and machine codes
   localparam logic [7:0]  ELF_MAG0      = 8'h7f;
   localparam logic [7:0]  ELF_MAG1      = 8'h45;
   localparam logic [7:0]  ELF_MAG2      = 8'h4c;
   localparam logic [7:0]  ELF_MAG3      = 8'h46;
   localparam logic [7:0]  ELF_CLASS64   = 8'h02;
   localparam logic [7:0]  ELF_DATA_LSB  = 8'h01;
   localparam logic [15:0] ELF_EM_X86_64 = 16'd62;
   localparam logic [15:0] ELF_EM_ARM64  = 16'd183;
   localparam logic [7:0]  WASM_MAG0     = 8'h00;
   localparam logic [7:0]  WASM_MAG1     = 8'h61;
   localparam logic [7:0]  WASM_MAG2     = 8'h73;
   localparam logic [7:0]  WASM_MAG3     = 8'h6d;
   localparam logic [31:0] WASM_VERSION  = 32'd1;
   localparam logic [31:0] MACHO_MAGIC64 = 32'hfeedfacf;
   localparam logic [31:0] MACHO_CPU_X86 = 32'h01000007;
   localparam logic [31:0] MACHO_CPU_ARM = 32'h0100000c;
   localparam logic [15:0] COFF_AMD64    = 16'h8664;
   localparam logic [15:0] COFF_ARM64    = 16'haa64;
   localparam logic [6:0]  MIN_HEADER    = 7'd8;
   localparam logic [6:0]  MIN_MACHO     = 7'd12;
   localparam logic [6:0]  MIN_FULL      = 7'd20;
   localparam logic [47:0] MIN_SIZE      = 48'd8;

   typedef enum logic [2:0] {
      FMT_NONE  = 3'd0,
      FMT_ELF64 = 3'd1,
      FMT_WASM  = 3'd2,
      FMT_MACHO = 3'd3,
      FMT_COFF  = 3'd4
   } fmt_type;

   typedef enum logic [1:0] {
      ARCH_NONE   = 2'd0,
      ARCH_X86_64 = 2'd1,
      ARCH_ARM64  = 2'd2,
      ARCH_WASM32 = 2'd3
   } arch_type;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_SIZE        = 4'd1,
      ST_SHORT       = 4'd2,
      ST_ELF_CLASS   = 4'd3,
      ST_ELF_MACHINE = 4'd4,
      ST_WASM_VER    = 4'd5,
      ST_SHORT_MACHO = 4'd6,
      ST_MACHO_CPU   = 4'd7,
      ST_SHORT_COFF  = 4'd8,
      ST_COFF_BOUNDS = 4'd9,
      ST_UNKNOWN     = 4'd10
   } status_type;

   typedef struct packed {
      logic [7:0]            data_byte;
      logic                  last_byte;
      logic [OHC_SIZE_W-1:0] stated_size;
   } req_type;

   typedef struct packed {
      logic [2:0]            format_code;
      logic [1:0]            arch_code;
      logic [3:0]            status_code;
      logic [OHC_SIZE_W-1:0] object_size;
   } rsp_type;

   // One finished file header waiting for classification
   typedef struct packed {
      logic [OHC_STORE_DEPTH-1:0][7:0] hdr;
      logic [OHC_CNT_W-1:0]            avail;
      logic [OHC_SIZE_W-1:0]           size;
   } snap_type;

   typedef struct packed {
      logic [47:0] max_object_size;
      logic [15:0] max_coff_sections;
      logic [15:0] max_coff_optional;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

[sv/object_header_classifier.sv]
// Channel  Ports                               Transaction
// req      req_valid, req_stall, req_data      one header byte, last flag, file size
// rsp      rsp_valid, rsp_stall, rsp_data      format, architecture, status, size
// csr      csr_psel .. csr_pready (64-bit)     limits at byte address 0, 8, 16
//
// One header byte is accepted every cycle unless stalled; the front only stores
// and counts. A finished header passes through a two-entry queue, which parts
// the front from the classifier, into the result register when that is free or
// draining. The input stalls only when two files wait behind a stalled result.
// Reset is synchronous and clears counts, queue and result valid; no clearing pass.
module object_header_classifier
   import ohc_pkg::*;
#(
   parameter int READ_WINDOW = OHC_READ_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [OHC_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg_ff;
   logic       csr_wr;
   logic [1:0] reg_idx;
   logic       push, pop;
   snap_type   snap, head;
   q_stat_type q_stat;

   // Register file
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_object_size   <= OHC_RST_MAX_SIZE;
         cfg_ff.max_coff_sections <= OHC_RST_MAX_SECS;
         cfg_ff.max_coff_optional <= OHC_RST_MAX_OPT;
      end else if (csr_wr) begin
         unique case (reg_idx)
            OHC_REG_MAX_SIZE: cfg_ff.max_object_size   <= csr_pwdata[47:0];
            OHC_REG_MAX_SECS: cfg_ff.max_coff_sections <= csr_pwdata[15:0];
            OHC_REG_MAX_OPT:  cfg_ff.max_coff_optional <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         OHC_REG_MAX_SIZE: csr_prdata = {16'd0, cfg_ff.max_object_size};
         OHC_REG_MAX_SECS: csr_prdata = {48'd0, cfg_ff.max_coff_sections};
         OHC_REG_MAX_OPT:  csr_prdata = {48'd0, cfg_ff.max_coff_optional};
         default:          csr_prdata = '0;
      endcase
   end

   ohc_front #(
      .READ_WINDOW(READ_WINDOW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_stat   (q_stat),
      .push     (push),
      .snap     (snap)
   );

   ohc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(snap),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   ohc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

[sv/ohc_front.sv]
module ohc_front
   import ohc_pkg::*;
#(
   parameter int READ_WINDOW = OHC_READ_WINDOW
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   input  q_stat_type q_stat,
   output logic       push,
   output snap_type   snap
);

   localparam logic [8:0] WIN = 9'(READ_WINDOW);

   logic [OHC_CNT_W-1:0]            cnt_ff, cnt_in, cnt_nx;
   logic [OHC_SIZE_W-1:0]           size_ff, size_in, size_cur;
   logic [OHC_STORE_DEPTH-1:0][7:0] header_ff, header_in;
   logic [OHC_CNT_W-1:0]            lim_win, lim;
   logic                            accept;

   // Stall only when the queue cannot take a finished header
   assign req_stall = q_stat.full;
   assign accept    = req_valid & ~req_stall;
   assign push      = accept & req_data.last_byte;

   // Saturating byte count of the current file
   assign cnt_nx = (cnt_ff == OHC_COUNT_MAX) ? OHC_COUNT_MAX : cnt_ff + 7'd1;

   // Sample the file size on the first byte of a file
   assign size_cur = (cnt_ff == '0) ? req_data.stated_size : size_ff;

   // Drop the byte into the store while there is room
   always_comb begin
      header_in = header_ff;
      if (cnt_ff < 7'(OHC_STORE_DEPTH)) begin
         header_in[cnt_ff[OHC_IDX_W-1:0]] = req_data.data_byte;
      end
   end

   // Usable length: smallest of count, window and stated size
   always_comb begin
      lim_win = ({2'b00, cnt_nx} > WIN) ? WIN[OHC_CNT_W-1:0] : cnt_nx;
      lim     = lim_win;
      if ({41'd0, lim_win} > size_cur) begin
         lim = size_cur[OHC_CNT_W-1:0];
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      size_in = size_ff;
      if (accept) begin
         cnt_in  = req_data.last_byte ? '0 : cnt_nx;
         size_in = size_cur;
      end
   end

   assign snap.hdr   = header_in;
   assign snap.avail = lim;
   assign snap.size  = size_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         size_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         size_ff <= size_in;
      end
   end

   // Header bytes carry no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         header_ff <= header_in;
      end
   end

endmodule

[sv/ohc_queue.sv]
module ohc_queue
   import ohc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  snap_type   push_data,
   input  logic       pop,
   output snap_type   head,
   output q_stat_type q_stat
);

   snap_type                entry_ff [OHC_QDEPTH];
   logic [OHC_QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OHC_QCNT_W-1:0]   count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == OHC_QCNT_W'(OHC_QDEPTH));
   assign q_stat.empty = (count_ff == '0);

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full && !pop |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue read while empty");

endmodule

[sv/ohc_back.sv]
module ohc_back
   import ohc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  snap_type   head,
   input  q_stat_type q_stat,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic [OHC_STORE_DEPTH-1:0][7:0] b;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   fmt_type    fmt;
   arch_type   arch;
   status_type st;
   logic [15:0] elf_mach, coff_mach, coff_secs, coff_opt;
   logic [31:0] word0, word1;
   logic        size_bad;

   // Take the next header when the output register is free or draining
   assign pop = ~q_stat.empty & (~rsp_valid_ff | ~rsp_stall);

   // Bytes past the usable length read as zero
   always_comb begin
      for (int i = 0; i < OHC_STORE_DEPTH; i++) begin
         b[i] = (head.avail > 7'(i)) ? head.hdr[i] : 8'h00;
      end
   end

   assign word0     = {b[3], b[2], b[1], b[0]};
   assign word1     = {b[7], b[6], b[5], b[4]};
   assign elf_mach  = {b[19], b[18]};
   assign coff_mach = {b[1], b[0]};
   assign coff_secs = {b[3], b[2]};
   assign coff_opt  = {b[17], b[16]};
   assign size_bad  = (head.size < MIN_SIZE) || (head.size > cfg.max_object_size);

   // Classify in file order; the first failing check wins
   always_comb begin
      fmt  = FMT_NONE;
      arch = ARCH_NONE;
      st   = ST_UNKNOWN;
      priority if (size_bad) begin
         st = ST_SIZE;
      end else if (head.avail < MIN_HEADER) begin
         st = ST_SHORT;
      end else if (b[0] == ELF_MAG0 && b[1] == ELF_MAG1 &&
                   b[2] == ELF_MAG2 && b[3] == ELF_MAG3) begin
         if (head.avail < MIN_FULL || b[4] != ELF_CLASS64 || b[5] != ELF_DATA_LSB) begin
            st = ST_ELF_CLASS;
         end else if (elf_mach == ELF_EM_X86_64) begin
            fmt = FMT_ELF64; arch = ARCH_X86_64; st = ST_OK;
         end else if (elf_mach == ELF_EM_ARM64) begin
            fmt = FMT_ELF64; arch = ARCH_ARM64; st = ST_OK;
         end else begin
            st = ST_ELF_MACHINE;
         end
      end else if (b[0] == WASM_MAG0 && b[1] == WASM_MAG1 &&
                   b[2] == WASM_MAG2 && b[3] == WASM_MAG3) begin
         if (word1 != WASM_VERSION) begin
            st = ST_WASM_VER;
         end else begin
            fmt = FMT_WASM; arch = ARCH_WASM32; st = ST_OK;
         end
      end else if (word0 == MACHO_MAGIC64) begin
         if (head.avail < MIN_MACHO) begin
            st = ST_SHORT_MACHO;
         end else if (word1 == MACHO_CPU_X86) begin
            fmt = FMT_MACHO; arch = ARCH_X86_64; st = ST_OK;
         end else if (word1 == MACHO_CPU_ARM) begin
            fmt = FMT_MACHO; arch = ARCH_ARM64; st = ST_OK;
         end else begin
            st = ST_MACHO_CPU;
         end
      end else if (coff_mach == COFF_AMD64 || coff_mach == COFF_ARM64) begin
         if (head.avail < MIN_FULL) begin
            st = ST_SHORT_COFF;
         end else if (coff_secs == '0 || coff_secs > cfg.max_coff_sections ||
                      coff_opt > cfg.max_coff_optional) begin
            st = ST_COFF_BOUNDS;
         end else begin
            fmt  = FMT_COFF;
            arch = (coff_mach == COFF_AMD64) ? ARCH_X86_64 : ARCH_ARM64;
            st   = ST_OK;
         end
      end else begin
         st = ST_UNKNOWN;
      end
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff.format_code <= fmt;
         rsp_data_ff.arch_code   <= arch;
         rsp_data_ff.status_code <= st;
         rsp_data_ff.object_size <= head.size;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fail_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status_code != ST_OK |->
         rsp_data_ff.format_code == FMT_NONE && rsp_data_ff.arch_code == ARCH_NONE)
      else $error("failure result carries a format or architecture");

   a_ok_has_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status_code == ST_OK |->
         rsp_data_ff.format_code != FMT_NONE && rsp_data_ff.arch_code != ARCH_NONE)
      else $error("ok result without format or architecture");

endmodule

[tb/tb_object_header_classifier.sv]
`timescale 1ns / 100ps

module tb_object_header_classifier;
   import ohc_pkg::*;

   localparam int READ_WIN     = 64;
   localparam int HDR_KEEP     = 20;
   localparam int IMG_MAX      = 160;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_NS   = 5_000_000;

   // Header shapes the generator can build
   typedef enum int {
      K_ELF_X86, K_ELF_ARM, K_ELF_CLASS, K_ELF_MACH,
      K_WASM, K_WASM_VER,
      K_MACHO_X86, K_MACHO_ARM, K_MACHO_CPU,
      K_COFF_AMD, K_COFF_ARM, K_COFF_NOSEC, K_COFF_SECS, K_COFF_OPT,
      K_NEAR, K_NOISE
   } hdr_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [OHC_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0]           csr_pwdata = '0;
   logic [63:0]           csr_prdata;
   logic                  csr_pready;

   // Shadow of the classifier: header bytes, count, latched size and limits
   logic [7:0]  hdr_store [HDR_KEEP];
   logic [6:0]  byte_count = '0;
   logic [47:0] size_hold = '0;
   logic [47:0] lim_size = 48'd536870912;
   logic [15:0] lim_secs = 16'd32768;
   logic [15:0] lim_opt  = 16'd4096;

   rsp_type     pending_class [$];
   rsp_type     want_class;
   logic [7:0]  img [IMG_MAX];

   int          idle_pct = 19;
   int          stall_pct = 19;
   int          hold_serial = 0;
   int          hold_seen = 0;
   int          err_count = 0;
   int          bytes_sent = 0;
   int          files_sent = 0;
   int          results_checked = 0;
   int          limit_sets = 0;
   int          in_stall_cycles = 0;
   logic [15:0] status_seen = '0;

   object_header_classifier DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Header bytes as the classifier sees them: zero past the usable length
   function automatic logic [7:0] hdr_at(int idx, int avail);
      if (idx >= HDR_KEEP || idx >= avail) return 8'h00;
      return hdr_store[idx];
   endfunction

   function automatic logic [15:0] hdr16(int idx, int avail);
      return {hdr_at(idx + 1, avail), hdr_at(idx, avail)};
   endfunction

   function automatic logic [31:0] hdr32(int idx, int avail);
      return {hdr16(idx + 2, avail), hdr16(idx, avail)};
   endfunction

   // Classify the file held in the shadow store
   function automatic rsp_type classify_header();
      rsp_type     verdict;
      int          avail;
      logic [15:0] elf_mach;
      logic [15:0] coff_mach;
      logic [15:0] secs;
      logic [15:0] opt;
      logic [31:0] cpu;
      avail = int'(byte_count);
      if (avail > READ_WIN) avail = READ_WIN;
      if (size_hold < 48'(avail)) avail = int'(size_hold[6:0]);
      verdict.format_code = FMT_NONE;
      verdict.arch_code   = ARCH_NONE;
      verdict.status_code = ST_UNKNOWN;
      verdict.object_size = size_hold;
      coff_mach = hdr16(0, avail);
      if (size_hold < 48'd8 || size_hold > lim_size) begin
         verdict.status_code = ST_SIZE;
      end else if (avail < 8) begin
         verdict.status_code = ST_SHORT;
      end else if (hdr32(0, avail) == 32'h464c457f) begin
         // ELF: 64-bit little-endian class, then machine at offset 18
         elf_mach = hdr16(18, avail);
         if (avail < 20 || hdr_at(4, avail) != 8'h02 || hdr_at(5, avail) != 8'h01) begin
            verdict.status_code = ST_ELF_CLASS;
         end else if (elf_mach == 16'd62 || elf_mach == 16'd183) begin
            verdict.format_code = FMT_ELF64;
            verdict.arch_code   = (elf_mach == 16'd62) ? ARCH_X86_64 : ARCH_ARM64;
            verdict.status_code = ST_OK;
         end else begin
            verdict.status_code = ST_ELF_MACHINE;
         end
      end else if (hdr32(0, avail) == 32'h6d736100) begin
         if (hdr32(4, avail) != 32'd1) begin
            verdict.status_code = ST_WASM_VER;
         end else begin
            verdict.format_code = FMT_WASM;
            verdict.arch_code   = ARCH_WASM32;
            verdict.status_code = ST_OK;
         end
      end else if (hdr32(0, avail) == 32'hfeedfacf) begin
         cpu = hdr32(4, avail);
         if (avail < 12) begin
            verdict.status_code = ST_SHORT_MACHO;
         end else if (cpu == 32'h01000007 || cpu == 32'h0100000c) begin
            verdict.format_code = FMT_MACHO;
            verdict.arch_code   = (cpu == 32'h01000007) ? ARCH_X86_64 : ARCH_ARM64;
            verdict.status_code = ST_OK;
         end else begin
            verdict.status_code = ST_MACHO_CPU;
         end
      end else if (coff_mach == 16'h8664 || coff_mach == 16'haa64) begin
         secs = hdr16(2, avail);
         opt  = hdr16(16, avail);
         if (avail < 20) begin
            verdict.status_code = ST_SHORT_COFF;
         end else if (secs == 16'd0 || secs > lim_secs || opt > lim_opt) begin
            verdict.status_code = ST_COFF_BOUNDS;
         end else begin
            verdict.format_code = FMT_COFF;
            verdict.arch_code   = (coff_mach == 16'h8664) ? ARCH_X86_64 : ARCH_ARM64;
            verdict.status_code = ST_OK;
         end
      end
      return verdict;
   endfunction

   // Advance the shadow by one accepted byte; queue a verdict on the last one
   task automatic absorb_byte(input req_type item);
      rsp_type verdict;
      if (byte_count == 7'd0) size_hold = item.stated_size;
      if (byte_count < 7'(HDR_KEEP)) hdr_store[byte_count] = item.data_byte;
      if (byte_count < 7'd127) byte_count++;
      bytes_sent++;
      if (item.last_byte) begin
         verdict = classify_header();
         status_seen[verdict.status_code] = 1'b1;
         pending_class.push_back(verdict);
         byte_count = 7'd0;
         files_sent++;
      end
   endtask

   // Offer one transaction, with a random gap in front, and hold it until taken
   task automatic send_byte(input req_type item);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      absorb_byte(item);
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Fill the image with random bytes and lay a header of the given shape over it
   task automatic build_header(input hdr_kind_type kind);
      logic [15:0] mach;
      logic [15:0] secs;
      logic [15:0] opt;
      logic [31:0] word;
      int          pick;
      for (int i = 0; i < IMG_MAX; i++) img[i] = 8'($urandom);
      case (kind)
         K_ELF_X86, K_ELF_ARM, K_ELF_CLASS, K_ELF_MACH: begin
            img[0] = 8'h7f; img[1] = 8'h45; img[2] = 8'h4c; img[3] = 8'h46;
            img[4] = 8'h02; img[5] = 8'h01;
            mach = (kind == K_ELF_ARM) ? 16'd183 : 16'd62;
            if (kind == K_ELF_MACH) begin
               mach = 16'($urandom);
               if (mach == 16'd62 || mach == 16'd183) mach = mach ^ 16'h0100;
            end
            if (kind == K_ELF_CLASS) begin
               pick = $urandom_range(254);
               if ($urandom_range(1)) img[4] = 8'((pick >= 2) ? pick + 1 : pick);
               else img[5] = 8'((pick >= 1) ? pick + 1 : pick);
            end
            img[18] = mach[7:0];
            img[19] = mach[15:8];
         end
         K_WASM, K_WASM_VER: begin
            img[0] = 8'h00; img[1] = 8'h61; img[2] = 8'h73; img[3] = 8'h6d;
            word = 32'd1;
            if (kind == K_WASM_VER) begin
               if ($urandom_range(1)) word = 32'd1 ^ (32'd1 << $urandom_range(31));
               else word = $urandom | 32'd2;
            end
            {img[7], img[6], img[5], img[4]} = word;
         end
         K_MACHO_X86, K_MACHO_ARM, K_MACHO_CPU: begin
            img[0] = 8'hcf; img[1] = 8'hfa; img[2] = 8'hed; img[3] = 8'hfe;
            word = (kind == K_MACHO_ARM) ? 32'h0100000c : 32'h01000007;
            if (kind == K_MACHO_CPU) word = word ^ (32'd1 << $urandom_range(31));
            {img[7], img[6], img[5], img[4]} = word;
         end
         K_COFF_AMD, K_COFF_ARM, K_COFF_NOSEC, K_COFF_SECS, K_COFF_OPT: begin
            mach = (kind == K_COFF_ARM || (kind != K_COFF_AMD && $urandom_range(1)))
                   ? 16'haa64 : 16'h8664;
            secs = (lim_secs == 16'd0) ? 16'($urandom_range(65535, 1))
                                       : 16'($urandom_range(lim_secs, 1));
            opt  = 16'($urandom_range(lim_opt, 0));
            if ($urandom_range(3) == 0) secs = lim_secs;
            if ($urandom_range(3) == 0) opt = lim_opt;
            if (kind == K_COFF_NOSEC) secs = 16'd0;
            if (kind == K_COFF_SECS) secs = (lim_secs == 16'hffff) ? 16'd0 : lim_secs + 16'd1;
            if (kind == K_COFF_OPT) begin
               if (lim_opt == 16'hffff) secs = 16'd0;
               else opt = lim_opt + 16'd1;
            end
            {img[1], img[0]}   = mach;
            {img[3], img[2]}   = secs;
            {img[17], img[16]} = opt;
         end
         K_NEAR: begin
            // Lay down one of the magics, then flip a single bit in it
            pick = $urandom_range(3);
            case (pick)
               0: {img[3], img[2], img[1], img[0]} = 32'h464c457f;
               1: {img[3], img[2], img[1], img[0]} = 32'h6d736100;
               2: {img[3], img[2], img[1], img[0]} = 32'hfeedfacf;
               default: {img[1], img[0]} = 16'h8664;
            endcase
            img[4] = 8'h02;
            img[5] = 8'h01;
            word = $urandom_range((pick == 3) ? 1 : 3);
            img[word] = img[word] ^ 8'(1 << $urandom_range(7));
         end
         default: ;
      endcase
   endtask

   // Send the first len bytes of the image as one file; size rides on the first
   task automatic send_file(input int len, input logic [47:0] size);
      req_type item;
      for (int i = 0; i < len; i++) begin
         item.data_byte   = img[i];
         item.last_byte   = (i == len - 1);
         item.stated_size = (i == 0) ? size : rand48();
         send_byte(item);
      end
   endtask

   task automatic directed_file(input hdr_kind_type kind, input int len,
                                input logic [47:0] size);
      build_header(kind);
      send_file(len, size);
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 6)  return $urandom_range(7, 1);
      if (r < 18) return $urandom_range(19, 8);
      if (r < 80) return $urandom_range(24, 20);
      if (r < 96) return $urandom_range(64, 25);
      return $urandom_range(140, 65);
   endfunction

   function automatic logic [47:0] pick_size(int len);
      int r;
      r = $urandom_range(99);
      if (r < 45) return 48'(len) + 48'($urandom_range(200));
      if (r < 58) return lim_size - 48'($urandom_range(3));
      if (r < 68) return lim_size + 48'($urandom_range(4, 1));
      if (r < 76) return 48'($urandom_range(7));
      if (r < 88) return 48'($urandom_range(len));
      return rand48();
   endfunction

   // Mostly well-formed headers with random content, some near misses and noise
   task automatic run_random(input int n_bytes);
      int           start;
      int           len;
      int           r;
      hdr_kind_type kind;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         r = $urandom_range(99);
         if (r < 8) kind = K_NOISE;
         else if (r < 15) kind = K_NEAR;
         else kind = hdr_kind_type'($urandom_range(K_COFF_OPT, K_ELF_X86));
         len = pick_len();
         build_header(kind);
         send_file(len, pick_size(len));
      end
   endtask

   // Drop valid and wait until every queued verdict has been matched
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (pending_class.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         OHC_REG_MAX_SIZE: lim_size = value[47:0];
         OHC_REG_MAX_SECS: lim_secs = value[15:0];
         OHC_REG_MAX_OPT:  lim_opt  = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read(input logic [1:0] idx, output logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Read every limit back and compare it with the shadow copy
   task automatic check_limits();
      logic [63:0] rd;
      csr_read(OHC_REG_MAX_SIZE, rd);
      if (rd[47:0] !== lim_size) begin
         $error("max_object_size: expected %0h, got %0h", lim_size, rd[47:0]);
         err_count++;
      end
      csr_read(OHC_REG_MAX_SECS, rd);
      if (rd[15:0] !== lim_secs) begin
         $error("max_coff_sections: expected %0h, got %0h", lim_secs, rd[15:0]);
         err_count++;
      end
      csr_read(OHC_REG_MAX_OPT, rd);
      if (rd[15:0] !== lim_opt) begin
         $error("max_coff_optional: expected %0h, got %0h", lim_opt, rd[15:0]);
         err_count++;
      end
   endtask

   // Write all limits once the block is idle; upper bits carry junk to be masked
   task automatic set_limits(input logic [47:0] size, input logic [15:0] secs,
                             input logic [15:0] opt);
      drain_results();
      csr_write(OHC_REG_MAX_SIZE, {16'($urandom), size});
      csr_write(OHC_REG_MAX_SECS, {rand48(), secs});
      csr_write(OHC_REG_MAX_OPT,  {rand48(), opt});
      check_limits();
      limit_sets++;
   endtask

   task automatic test_register_access();
      check_limits();
   endtask

   task automatic test_directed_headers();
      directed_file(K_ELF_X86,    20, 48'd4096);
      directed_file(K_ELF_ARM,    64, 48'd64);
      directed_file(K_ELF_CLASS,  20, 48'd1000);
      directed_file(K_ELF_MACH,   24, 48'd1000);
      // ELF with fewer than 20 bytes fails the class check
      directed_file(K_ELF_X86,    19, 48'd1000);
      directed_file(K_WASM,        8, 48'd8);
      directed_file(K_WASM_VER,   12, 48'd12);
      directed_file(K_MACHO_X86,  12, 48'd32);
      directed_file(K_MACHO_ARM,  32, 48'd32);
      directed_file(K_MACHO_X86,  11, 48'd32);
      directed_file(K_MACHO_CPU,  16, 48'd16);
      directed_file(K_COFF_AMD,   20, 48'd512);
      directed_file(K_COFF_ARM,   20, 48'd512);
      directed_file(K_COFF_AMD,   19, 48'd512);
      directed_file(K_COFF_NOSEC, 20, 48'd512);
      directed_file(K_COFF_SECS,  20, 48'd512);
      directed_file(K_COFF_OPT,   20, 48'd512);
      // No known magic at all
      build_header(K_NOISE);
      img[0] = 8'h12;
      img[1] = 8'h34;
      send_file(20, 48'd20);
      // Size bounds: below minimum, zero, at and just past the limit, maximum
      directed_file(K_WASM, 8, 48'd7);
      directed_file(K_WASM, 8, 48'd0);
      directed_file(K_WASM, 8, lim_size);
      directed_file(K_WASM, 8, lim_size + 48'd1);
      directed_file(K_WASM, 8, 48'hffff_ffff_ffff);
      // Short header, and a file that ends on its first byte
      directed_file(K_WASM, 7, 48'd100);
      directed_file(K_WASM, 1, 48'd100);
      // Stated size shorter than the bytes sent trims the usable header
      directed_file(K_ELF_X86, 20, 48'd10);
      // All-ones bytes past the store and past the count saturation, then all zeros
      for (int i = 0; i < IMG_MAX; i++) img[i] = 8'hff;
      send_file(140, 48'd140);
      for (int i = 0; i < IMG_MAX; i++) img[i] = 8'h00;
      send_file(20, 48'd20);
   endtask

   task automatic test_random_default_limits();
      run_random(80);
   endtask

   task automatic test_limit_extremes();
      set_limits(48'hffff_ffff_ffff, 16'hffff, 16'hffff);
      run_random(50);
      set_limits(48'd8, 16'd1, 16'd0);
      run_random(50);
      // A section limit of zero rejects every COFF header
      set_limits(48'd100, 16'd0, 16'd100);
      run_random(50);
   endtask

   task automatic test_random_limits();
      logic [47:0] size;
      int          r;
      repeat (3) begin
         r = $urandom_range(2);
         if (r == 0) size = rand48();
         else if (r == 1) size = 48'($urandom_range(4096));
         else size = 48'($urandom_range(200, 8));
         set_limits(size, 16'($urandom), ($urandom_range(1)) ? 16'($urandom)
                                                              : 16'($urandom_range(64)));
         run_random(50);
      end
   endtask

   task automatic test_streaming();
      set_limits(48'd536870912, 16'd32768, 16'd4096);
      idle_pct  = 0;
      stall_pct = 0;
      run_random(100);
      idle_pct  = 19;
      stall_pct = 19;
   endtask

   // Hold the result side while short files keep arriving so the input stalls
   task automatic test_backpressure();
      drain_results();
      idle_pct = 0;
      hold_serial++;
      repeat (16) directed_file(($urandom_range(1)) ? K_WASM : K_MACHO_ARM, 8, 48'd64);
      idle_pct = 19;
   endtask

   // Result side: random stalls, or a long hold when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_seen != hold_serial) begin
            hold_seen = hold_serial;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= !reset && stall_pct != 0 && $urandom_range(99) < stall_pct;
         end
      end
   end

   // Match every accepted result with the oldest queued verdict
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) in_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_class.size() == 0) begin
               $error("unexpected result: format %0d arch %0d status %0d size %0h",
                      rsp_data.format_code, rsp_data.arch_code, rsp_data.status_code,
                      rsp_data.object_size);
               err_count++;
            end else begin
               want_class = pending_class.pop_front();
               results_checked++;
               if (rsp_data.format_code !== want_class.format_code) begin
                  $error("format_code: expected %0d, got %0d",
                         want_class.format_code, rsp_data.format_code);
                  err_count++;
               end
               if (rsp_data.arch_code !== want_class.arch_code) begin
                  $error("arch_code: expected %0d, got %0d",
                         want_class.arch_code, rsp_data.arch_code);
                  err_count++;
               end
               if (rsp_data.status_code !== want_class.status_code) begin
                  $error("status_code: expected %0d, got %0d",
                         want_class.status_code, rsp_data.status_code);
                  err_count++;
               end
               if (rsp_data.object_size !== want_class.object_size) begin
                  $error("object_size: expected %0h, got %0h",
                         want_class.object_size, rsp_data.object_size);
                  err_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_register_access();
      test_directed_headers();
      test_random_default_limits();
      test_limit_extremes();
      test_random_limits();
      test_streaming();
      test_backpressure();
      drain_results();
      $display("Checked %0d classifications from %0d header bytes over %0d limit settings",
               results_checked, bytes_sent, limit_sets);
      $display("Status codes reached (bit per code) %b, input held off for %0d cycles",
               status_seen, in_stall_cycles);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #(TIMEOUT_NS);
      $error("run did not finish in time, %0d results still pending", pending_class.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
